// ----- rtl/core/chsi_pkg.sv -----
// shared constants and types of the cubic hermite sample interpolator
package chsi_pkg;

  localparam int TIME_W = 64;
  localparam int FRAC_W = 32;
  localparam int T_W    = 33;
  localparam int QUO_W  = 58;
  localparam int ACC_W  = 64;
  localparam int PART_W = 32;

  localparam logic [QUO_W-1:0] SLOPE_LIMIT = 58'h0100_0000_0000_0000;

  typedef struct packed {
    logic on_prev;
    logic on_next;
    logic bad;
  } chsi_flags_t;

endpackage

// ----- rtl/core/chsi_mul.sv -----
// pipelined unsigned multiplier built from 32x32 partial products, three stages
module chsi_mul #(
  parameter int LANES  = 1,
  parameter int AW     = 64,
  parameter int BW     = 64,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][AW-1:0]      in_a,
  input  logic [LANES-1:0][BW-1:0]      in_b,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [LANES-1:0][AW+BW-1:0]   out_prod,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int HW = chsi_pkg::PART_W;
  localparam int FW = 2 * HW;
  localparam int PW = AW + BW;

  logic [2:0]                 vld_r;
  logic [SIDE_W-1:0]          side_r [3];
  logic [LANES-1:0][FW-1:0]   p00_r, p01_r, p10_r, p11_r;
  logic [LANES-1:0][FW-1:0]   p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic [LANES-1:0][FW-1:0]   lo_r, hi_r;
  logic [LANES-1:0][FW:0]     mid_r, mid_nxt;
  logic [LANES-1:0][PW-1:0]   prod_r, prod_nxt;

  always_comb begin
    logic [FW-1:0]   a;
    logic [FW-1:0]   b;
    logic [2*FW-1:0] sum;
    for (int l = 0; l < LANES; l++) begin
      a = FW'(in_a[l]);
      b = FW'(in_b[l]);
      p00_nxt[l] = FW'(a[HW-1:0]) * FW'(b[HW-1:0]);
      p01_nxt[l] = FW'(a[HW-1:0]) * FW'(b[FW-1:HW]);
      p10_nxt[l] = FW'(a[FW-1:HW]) * FW'(b[HW-1:0]);
      p11_nxt[l] = FW'(a[FW-1:HW]) * FW'(b[FW-1:HW]);
      mid_nxt[l] = {1'b0, p01_r[l]} + {1'b0, p10_r[l]};
      sum = {hi_r[l], lo_r[l]} + ((2*FW)'(mid_r[l]) << HW);
      prod_nxt[l] = PW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r     <= p00_nxt;
      p01_r     <= p01_nxt;
      p10_r     <= p10_nxt;
      p11_r     <= p11_nxt;
      lo_r      <= p00_r;
      hi_r      <= p11_r;
      mid_r     <= mid_nxt;
      prod_r    <= prod_nxt;
      side_r[0] <= in_side;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
    end
  end

  assign out_valid = vld_r[2];
  assign out_prod  = prod_r;
  assign out_side  = side_r[2];

endmodule

// ----- rtl/core/chsi_div.sv -----
// pipelined restoring divider, one quotient bit per stage, flagging overflow on out_sat
module chsi_div #(
  parameter int LANES  = 1,
  parameter int NW     = 97,
  parameter int DW     = 64,
  parameter int QW     = 58,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [LANES-1:0][DW-1:0]   in_den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [LANES-1:0]           out_sat,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam int NS = QW + 1;

  logic [NS-1:0]                vld_r;
  logic [SIDE_W-1:0]            side_r  [NS];
  logic [LANES-1:0][DW-1:0]     rem_r   [NS];
  logic [LANES-1:0][DW-1:0]     rem_nxt [NS];
  logic [LANES-1:0][QW-1:0]     low_r   [NS];
  logic [LANES-1:0][QW-1:0]     low_nxt [NS];
  logic [LANES-1:0][QW-1:0]     quo_r   [NS];
  logic [LANES-1:0][QW-1:0]     quo_nxt [NS];
  logic [LANES-1:0][DW-1:0]     den_r   [NS];
  logic [LANES-1:0][DW-1:0]     den_nxt [NS];
  logic [LANES-1:0]             sat_r   [NS];
  logic [LANES-1:0]             sat_nxt [NS];

  always_comb begin
    logic [HW-1:0] hi_part;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    // entry: quotient overflows when the high part already reaches the divisor
    for (int l = 0; l < LANES; l++) begin
      hi_part         = in_num[l][NW-1:QW];
      sat_nxt[0][l]   = CW'(hi_part) >= CW'(in_den[l]);
      rem_nxt[0][l]   = DW'(hi_part);
      low_nxt[0][l]   = in_num[l][QW-1:0];
      quo_nxt[0][l]   = '0;
      den_nxt[0][l]   = in_den[l];
    end
    for (int s = 1; s < NS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_r[s-1][l], low_r[s-1][l][QW-1]};
        diff  = trial - {1'b0, den_r[s-1][l]};
        ge    = trial >= {1'b0, den_r[s-1][l]};
        rem_nxt[s][l] = ge ? diff[DW-1:0] : trial[DW-1:0];
        low_nxt[s][l] = low_r[s-1][l] << 1;
        quo_nxt[s][l] = {quo_r[s-1][l][QW-2:0], ge};
        den_nxt[s][l] = den_r[s-1][l];
        sat_nxt[s][l] = sat_r[s-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int s = 0; s < NS; s++) begin
        rem_r[s] <= rem_nxt[s];
        low_r[s] <= low_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= den_nxt[s];
        sat_r[s] <= sat_nxt[s];
      end
      for (int s = 1; s < NS; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_quo   = quo_r[NS-1];
  assign out_sat   = sat_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// ----- rtl/core/cubic_hermite_sample_interpolator.sv -----
// top level of the four-point cubic hermite sample interpolator
//
// Takes one word per cycle while the chain is not stalled: a target time and
// four timed samples (64-bit nanosecond stamps, signed Q16.16 values) and
// returns one word per input: the cubic Hermite value between samples 1
// and 2, end slopes being the mean of the neighbouring secants, rounded and
// saturated. A target equal to a stamp of sample 1 or 2 returns that sample
// unchanged; otherwise stamps that are not strictly increasing return zero
// with out_bad_spacing set. The datapath is a fully pipelined chain: input
// stage, secant multiply, numerator stage, restoring divider (entry check
// plus one quotient bit per stage for 58 bits), slope and coefficient
// stages, three Horner steps (magnitude, 3-stage multiply, round and add),
// rounding stage and output stage.
// Backpressure stalls the whole chain at once: in_stall is high only while a
// finished word sits in the output register with out_stall high.
module cubic_hermite_sample_interpolator #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [63:0]                    in_target_time,
  input  logic [63:0]                    in_time_before_prev,
  input  logic signed [VALUE_WIDTH-1:0]  in_value_before_prev,
  input  logic [63:0]                    in_time_prev,
  input  logic signed [VALUE_WIDTH-1:0]  in_value_prev,
  input  logic [63:0]                    in_time_next,
  input  logic signed [VALUE_WIDTH-1:0]  in_value_next,
  input  logic [63:0]                    in_time_after_next,
  input  logic signed [VALUE_WIDTH-1:0]  in_value_after_next,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [VALUE_WIDTH-1:0]  out_interpolated_value,
  output logic                           out_bad_spacing
);

  localparam int VW     = VALUE_WIDTH;
  localparam int DYW    = VW + 1;
  localparam int TW     = chsi_pkg::TIME_W;
  localparam int FW     = chsi_pkg::FRAC_W;
  localparam int AW     = chsi_pkg::ACC_W;
  localparam int QW     = chsi_pkg::QUO_W;
  localparam int TQW    = chsi_pkg::T_W;
  localparam int PW1    = DYW + TW;
  localparam int NUM_T  = TW + FW + 1;
  localparam int NUM_W  = (PW1 + 1 > NUM_T) ? PW1 + 1 : NUM_T;
  localparam int HPW    = AW + TQW;

  localparam logic [HPW-1:0] HALF_ULP = HPW'(1) << (FW - 1);
  localparam logic [AW-1:0]  POS_MAX  = (AW'(1) << (VW - 1)) - AW'(1);
  localparam logic [AW-1:0]  NEG_MAG  = AW'(1) << (VW - 1);

  // per-stage sideband records
  typedef struct packed {
    chsi_pkg::chsi_flags_t   flg;
    logic signed [VW-1:0]    y1;
    logic signed [VW-1:0]    y2;
    logic signed [DYW-1:0]   delta;
    logic                    neg0;
    logic                    neg2;
    logic [TW-1:0]           h;
    logic [TW-1:0]           h0;
    logic [TW-1:0]           h2;
    logic [TW-1:0]           u;
  } sa_t;

  typedef struct packed {
    chsi_pkg::chsi_flags_t   flg;
    logic signed [VW-1:0]    y1;
    logic signed [VW-1:0]    y2;
    logic signed [DYW-1:0]   delta;
    logic                    neg0;
    logic                    neg2;
  } sd_t;

  typedef struct packed {
    chsi_pkg::chsi_flags_t   flg;
    logic signed [VW-1:0]    y1;
    logic signed [VW-1:0]    y2;
    logic signed [DYW-1:0]   delta;
    logic [TQW-1:0]          t;
    logic signed [AW-1:0]    d1;
    logic signed [AW-1:0]    d2;
  } sc_t;

  typedef struct packed {
    chsi_pkg::chsi_flags_t   flg;
    logic signed [VW-1:0]    y1;
    logic signed [VW-1:0]    y2;
    logic [TQW-1:0]          t;
    logic signed [AW-1:0]    c2;
    logic signed [AW-1:0]    d1;
  } hs_t;

  typedef struct packed {
    logic                    neg;
    hs_t                     hs;
  } hm_t;

  // global advance: the chain moves unless the output word is held
  logic en;
  logic out_valid_r;
  logic signed [VW-1:0] out_value_r;
  logic out_bad_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------- stage a
  // interval widths, clamped offset, sample differences and special cases
  logic                  a_valid_r;
  sa_t                   a_side_r, a_side_nxt;
  logic [1:0][DYW-1:0]   a_mag_r, a_mag_nxt;

  always_comb begin
    logic signed [DYW-1:0] dy0;
    logic signed [DYW-1:0] dy2;
    a_side_nxt.flg.on_prev = in_target_time == in_time_prev;
    a_side_nxt.flg.on_next = in_target_time == in_time_next;
    a_side_nxt.flg.bad     = !((in_time_before_prev < in_time_prev) &&
                               (in_time_prev < in_time_next) &&
                               (in_time_next < in_time_after_next));
    a_side_nxt.y1    = in_value_prev;
    a_side_nxt.y2    = in_value_next;
    a_side_nxt.delta = DYW'(in_value_next) - DYW'(in_value_prev);
    a_side_nxt.h     = in_time_next - in_time_prev;
    a_side_nxt.h0    = in_time_prev - in_time_before_prev;
    a_side_nxt.h2    = in_time_after_next - in_time_next;
    // target outside the interval is clamped to its ends
    if (in_target_time < in_time_prev) begin
      a_side_nxt.u = '0;
    end else if (in_target_time > in_time_next) begin
      a_side_nxt.u = in_time_next - in_time_prev;
    end else begin
      a_side_nxt.u = in_target_time - in_time_prev;
    end
    dy0 = DYW'(in_value_prev) - DYW'(in_value_before_prev);
    dy2 = DYW'(in_value_after_next) - DYW'(in_value_next);
    a_side_nxt.neg0 = dy0[DYW-1];
    a_side_nxt.neg2 = dy2[DYW-1];
    a_mag_nxt[0] = dy0[DYW-1] ? DYW'(-dy0) : DYW'(dy0);
    a_mag_nxt[1] = dy2[DYW-1] ? DYW'(-dy2) : DYW'(dy2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      a_mag_r  <= a_mag_nxt;
    end
  end

  // ------------------------------------------------- secant numerator product
  // |dy| * h for the two outer secants
  logic                  m1_valid;
  logic [1:0][PW1-1:0]   m1_prod;
  sa_t                   m1_side;
  logic [1:0][TW-1:0]    m1_b;

  assign m1_b = {a_side_r.h, a_side_r.h};

  chsi_mul #(
    .LANES  (2),
    .AW     (DYW),
    .BW     (TW),
    .SIDE_W ($bits(sa_t))
  ) u_chsi_mul_sec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_valid_r),
    .in_a      (a_mag_r),
    .in_b      (m1_b),
    .in_side   (a_side_r),
    .out_valid (m1_valid),
    .out_prod  (m1_prod),
    .out_side  (m1_side)
  );

  // ---------------------------------------------------------------- stage b
  // rounded numerators: lane 0 and 1 are secants, lane 2 is the phase t
  logic                    b_valid_r;
  logic [2:0][NUM_W-1:0]   b_num_r, b_num_nxt;
  logic [2:0][TW-1:0]      b_den_r, b_den_nxt;
  sd_t                     b_side_r, b_side_nxt;

  always_comb begin
    b_num_nxt[0] = NUM_W'(m1_prod[0]) + NUM_W'(m1_side.h0 >> 1);
    b_num_nxt[1] = NUM_W'(m1_prod[1]) + NUM_W'(m1_side.h2 >> 1);
    b_num_nxt[2] = NUM_W'({m1_side.u, FW'(0)}) + NUM_W'(m1_side.h >> 1);
    b_den_nxt[0] = m1_side.h0;
    b_den_nxt[1] = m1_side.h2;
    b_den_nxt[2] = m1_side.h;
    b_side_nxt.flg   = m1_side.flg;
    b_side_nxt.y1    = m1_side.y1;
    b_side_nxt.y2    = m1_side.y2;
    b_side_nxt.delta = m1_side.delta;
    b_side_nxt.neg0  = m1_side.neg0;
    b_side_nxt.neg2  = m1_side.neg2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_num_r  <= b_num_nxt;
      b_den_r  <= b_den_nxt;
      b_side_r <= b_side_nxt;
    end
  end

  // ---------------------------------------------------------------- divider
  logic                 dv_valid;
  logic [2:0][QW-1:0]   dv_quo;
  logic [2:0]           dv_sat;
  sd_t                  dv_side;

  chsi_div #(
    .LANES  (3),
    .NW     (NUM_W),
    .DW     (TW),
    .QW     (QW),
    .SIDE_W ($bits(sd_t))
  ) u_chsi_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .in_num    (b_num_r),
    .in_den    (b_den_r),
    .in_side   (b_side_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_sat   (dv_sat),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------- stage c
  // saturate scaled secants and form the doubled end tangents d1, d2
  logic  c_valid_r;
  sc_t   c_side_r, c_side_nxt;

  always_comb begin
    logic [QW-1:0]        mag0;
    logic [QW-1:0]        mag2;
    logic signed [AW-1:0] s0;
    logic signed [AW-1:0] s2;
    logic signed [AW-1:0] dl;
    mag0 = (dv_sat[0] || (dv_quo[0] > chsi_pkg::SLOPE_LIMIT)) ?
           chsi_pkg::SLOPE_LIMIT : dv_quo[0];
    mag2 = (dv_sat[1] || (dv_quo[1] > chsi_pkg::SLOPE_LIMIT)) ?
           chsi_pkg::SLOPE_LIMIT : dv_quo[1];
    s0 = AW'(mag0);
    s2 = AW'(mag2);
    if (dv_side.neg0) begin
      s0 = -s0;
    end
    if (dv_side.neg2) begin
      s2 = -s2;
    end
    dl = AW'(dv_side.delta);
    c_side_nxt.flg   = dv_side.flg;
    c_side_nxt.y1    = dv_side.y1;
    c_side_nxt.y2    = dv_side.y2;
    c_side_nxt.delta = dv_side.delta;
    c_side_nxt.t     = TQW'(dv_quo[2]);
    c_side_nxt.d1    = s0 + dl;
    c_side_nxt.d2    = dl + s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= c_side_nxt;
    end
  end

  // ---------------------------------------------------------------- stage d
  // cubic coefficients c2 and c3
  logic                 d_valid_r;
  logic signed [AW-1:0] d_acc_r, d_acc_nxt;
  hs_t                  d_side_r, d_side_nxt;

  always_comb begin
    logic signed [AW-1:0] dl;
    dl = AW'(c_side_r.delta);
    d_side_nxt.flg = c_side_r.flg;
    d_side_nxt.y1  = c_side_r.y1;
    d_side_nxt.y2  = c_side_r.y2;
    d_side_nxt.t   = c_side_r.t;
    d_side_nxt.d1  = c_side_r.d1;
    d_side_nxt.c2  = (dl <<< 2) + (dl <<< 1) - (c_side_r.d1 <<< 1) - c_side_r.d2;
    d_acc_nxt      = c_side_r.d1 + c_side_r.d2 - (dl <<< 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_acc_r  <= d_acc_nxt;
      d_side_r <= d_side_nxt;
    end
  end

  // ----------------------------------------------------------- horner steps
  // acc = coef + round(acc * t / 2^32), coef is c2, then d1, then 2*y1
  logic                 hz_valid [4];
  logic signed [AW-1:0] hz_acc   [4];
  hs_t                  hz_side  [4];

  assign hz_valid[0] = d_valid_r;
  assign hz_acc[0]   = d_acc_r;
  assign hz_side[0]  = d_side_r;

  for (genvar k = 0; k < 3; k++) begin : g_horner
    logic                 mg_valid_r;
    logic [AW-1:0]        mg_mag_r;
    hm_t                  mg_side_r;
    logic                 ml_valid;
    logic [HPW-1:0]       ml_prod;
    hm_t                  ml_side;
    logic signed [AW-1:0] coef;
    logic [HPW-1:0]       rnd;
    logic signed [AW-1:0] term;
    logic                 fn_valid_r;
    logic signed [AW-1:0] fn_acc_r;
    hs_t                  fn_side_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mg_valid_r <= 1'b0;
      end else if (en) begin
        mg_valid_r <= hz_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mg_mag_r      <= hz_acc[k][AW-1] ? AW'(-hz_acc[k]) : AW'(hz_acc[k]);
        mg_side_r.neg <= hz_acc[k][AW-1];
        mg_side_r.hs  <= hz_side[k];
      end
    end

    chsi_mul #(
      .LANES  (1),
      .AW     (AW),
      .BW     (TQW),
      .SIDE_W ($bits(hm_t))
    ) u_chsi_mul_hz (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (mg_valid_r),
      .in_a      (mg_mag_r),
      .in_b      (mg_side_r.hs.t),
      .in_side   (mg_side_r),
      .out_valid (ml_valid),
      .out_prod  (ml_prod),
      .out_side  (ml_side)
    );

    if (k == 0) begin : g_c2
      assign coef = ml_side.hs.c2;
    end else if (k == 1) begin : g_d1
      assign coef = ml_side.hs.d1;
    end else begin : g_y1
      assign coef = AW'(ml_side.hs.y1) <<< 1;
    end

    // round half away from zero on the magnitude, then restore the sign
    always_comb begin
      rnd  = ml_prod + HALF_ULP;
      term = rnd[FW +: AW];
      if (ml_side.neg) begin
        term = -term;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fn_valid_r <= 1'b0;
      end else if (en) begin
        fn_valid_r <= ml_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fn_acc_r  <= coef + term;
        fn_side_r <= ml_side.hs;
      end
    end

    assign hz_valid[k+1] = fn_valid_r;
    assign hz_acc[k+1]   = fn_acc_r;
    assign hz_side[k+1]  = fn_side_r;
  end

  // ---------------------------------------------------------------- stage r
  // halve the doubled value, rounding half away from zero
  logic           r_valid_r;
  logic           r_neg_r;
  logic [AW-1:0]  r_mag_r, r_mag_nxt;
  hs_t            r_side_r;

  always_comb begin
    logic [AW-1:0] sum;
    if (hz_acc[3][AW-1]) begin
      sum = ~hz_acc[3] + AW'(2);
    end else begin
      sum = hz_acc[3] + AW'(1);
    end
    r_mag_nxt = sum >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else if (en) begin
      r_valid_r <= hz_valid[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_neg_r  <= hz_acc[3][AW-1];
      r_mag_r  <= r_mag_nxt;
      r_side_r <= hz_side[3];
    end
  end

  // ----------------------------------------------------------- output stage
  // saturation and the special cases, sample-1 hit first
  logic signed [VW-1:0] out_value_nxt;
  logic                 out_bad_nxt;

  always_comb begin
    out_bad_nxt = 1'b0;
    if (r_side_r.flg.on_prev) begin
      out_value_nxt = r_side_r.y1;
    end else if (r_side_r.flg.on_next) begin
      out_value_nxt = r_side_r.y2;
    end else if (r_side_r.flg.bad) begin
      out_value_nxt = '0;
      out_bad_nxt   = 1'b1;
    end else if (r_neg_r) begin
      out_value_nxt = (r_mag_r > NEG_MAG) ? VW'(NEG_MAG) : VW'(-r_mag_r);
    end else begin
      out_value_nxt = (r_mag_r > POS_MAX) ? VW'(POS_MAX) : VW'(r_mag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= out_value_nxt;
      out_bad_r   <= out_bad_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_interpolated_value = out_value_r;
  assign out_bad_spacing        = out_bad_r;

endmodule

// ----- rtl/core/chsi_checker.sv -----
// port-level checks of the cubic hermite sample interpolator and their bind
module chsi_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [VALUE_WIDTH-1:0] out_interpolated_value,
  input logic                          out_bad_spacing
);

  // a held output word keeps its contents
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_interpolated_value) &&
                               $stable(out_bad_spacing))
    else $error("output word changed while stalled");

  // bad spacing always reports a zero value
  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_spacing |-> out_interpolated_value == '0)
    else $error("bad spacing with nonzero value");

  // input only stalls behind a held output word
  a_in_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind cubic_hermite_sample_interpolator chsi_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_chsi_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_interpolated_value (out_interpolated_value),
  .out_bad_spacing        (out_bad_spacing)
);
